// ===== hw/rtl/mcv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcv_pkg
// Shared types and constants of the multibyte charset validator.
// ----------------------------------------------------------------------------
package mcv_pkg;

	localparam int MAX_STRING_BYTES = 4096;

	localparam int MODE_W = 2;
	localparam int KIND_W = 2;

	localparam logic [MODE_W-1:0] MODE_SJIS  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BIG5  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_IDENT = 2'd2;

	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LEAD   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TRAIL  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_BAD    = 2'd3;

	typedef struct packed {
		logic is_single;
		logic is_lead;
		logic is_trail;
	} byte_class_t;

endpackage

// ===== hw/rtl/mcv_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcv_classify
// Range decode of one byte into single, lead and trail classes per encoding.
// ----------------------------------------------------------------------------
module mcv_classify (
	input  logic [mcv_pkg::MODE_W-1:0] mode,
	input  logic [7:0]                 data_byte,
	output mcv_pkg::byte_class_t       cls
);

	always_comb begin
		cls = '0;
		case (mode)
			mcv_pkg::MODE_SJIS: begin
				cls.is_single = data_byte inside {[8'h21:8'h7E], [8'hA1:8'hDF]};
				cls.is_lead   = data_byte inside {[8'h81:8'h9F], [8'hE0:8'hEF]};
				cls.is_trail  = data_byte inside {[8'h40:8'h7E], [8'h80:8'hFC]};
			end
			mcv_pkg::MODE_BIG5: begin
				cls.is_single = data_byte inside {[8'h00:8'h7F]};
				cls.is_lead   = data_byte inside {[8'hA1:8'hF9]};
				cls.is_trail  = data_byte inside {[8'h40:8'h7E], [8'hA1:8'hFE]};
			end
			default: begin
				// identifier mode, unused code included
				cls.is_single = data_byte inside {[8'h30:8'h39], [8'h41:8'h5A],
					[8'h61:8'h7A], 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h5F, 8'h2D};
			end
		endcase
	end

endmodule

// ===== hw/rtl/mcv_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcv_track
// Per-string state: pending lead, offsets, character count, sticky error.
// Produces the verdict for the current item and advances the state.
// ----------------------------------------------------------------------------
module mcv_track #(
	parameter int MAX_STRING_BYTES = mcv_pkg::MAX_STRING_BYTES,
	parameter int OFFSET_W         = $clog2(MAX_STRING_BYTES),
	parameter int COUNT_W          = $clog2(MAX_STRING_BYTES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  mcv_pkg::byte_class_t       cls,
	input  logic                       last,
	output logic [mcv_pkg::KIND_W-1:0] kind,
	output logic [COUNT_W-1:0]         count,
	output logic                       err,
	output logic [OFFSET_W-1:0]        err_offset
);

	localparam logic [COUNT_W-1:0]  COUNT_MAX  = COUNT_W'(MAX_STRING_BYTES);
	localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(MAX_STRING_BYTES - 1);

	logic                expect_trail_q;
	logic [OFFSET_W-1:0] byte_offset_q;
	logic [COUNT_W-1:0]  char_counter_q;
	logic [OFFSET_W-1:0] lead_offset_q;
	logic                error_flag_q;
	logic [OFFSET_W-1:0] first_error_offset_q;

	logic                expect_n;
	logic [OFFSET_W-1:0] lead_n;
	logic                bump;
	logic                latch;
	logic [OFFSET_W-1:0] latch_offset;
	logic                err_n;
	logic [OFFSET_W-1:0] first_n;
	logic [COUNT_W-1:0]  count_n;
	logic [OFFSET_W-1:0] offset_n;

	always_comb begin
		kind         = mcv_pkg::KIND_BAD;
		expect_n     = 1'b0;
		lead_n       = lead_offset_q;
		bump         = 1'b0;
		latch        = 1'b0;
		latch_offset = byte_offset_q;
		if (error_flag_q) begin
			bump = 1'b1;
		end else if (expect_trail_q) begin
			if (cls.is_trail) begin
				kind = mcv_pkg::KIND_TRAIL;
			end else begin
				latch        = 1'b1;
				latch_offset = lead_offset_q;
			end
		end else begin
			bump = 1'b1;
			if (cls.is_single) begin
				kind = mcv_pkg::KIND_SINGLE;
			end else if (cls.is_lead) begin
				kind     = mcv_pkg::KIND_LEAD;
				lead_n   = byte_offset_q;
				expect_n = 1'b1;
			end else begin
				latch = 1'b1;
			end
		end
		// lead byte at end of string
		if (last && expect_n) begin
			kind         = mcv_pkg::KIND_BAD;
			expect_n     = 1'b0;
			latch        = 1'b1;
			latch_offset = lead_n;
		end
		err_n   = error_flag_q | latch;
		first_n = (latch && !error_flag_q) ? latch_offset : first_error_offset_q;
		count_n = (bump && char_counter_q < COUNT_MAX) ? char_counter_q + 1'b1
			: char_counter_q;
		offset_n = (byte_offset_q < OFFSET_MAX) ? byte_offset_q + 1'b1 : byte_offset_q;
	end

	assign count      = count_n;
	assign err        = err_n;
	assign err_offset = err_n ? first_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_trail_q       <= 1'b0;
			byte_offset_q        <= '0;
			char_counter_q       <= '0;
			lead_offset_q        <= '0;
			error_flag_q         <= 1'b0;
			first_error_offset_q <= '0;
		end else if (adv) begin
			if (last) begin
				expect_trail_q       <= 1'b0;
				byte_offset_q        <= '0;
				char_counter_q       <= '0;
				lead_offset_q        <= '0;
				error_flag_q         <= 1'b0;
				first_error_offset_q <= '0;
			end else begin
				expect_trail_q       <= expect_n;
				byte_offset_q        <= offset_n;
				char_counter_q       <= count_n;
				lead_offset_q        <= lead_n;
				error_flag_q         <= err_n;
				first_error_offset_q <= first_n;
			end
		end
	end

endmodule

// ===== hw/rtl/multibyte_charset_validator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multibyte_charset_validator_top
// Byte stream validator for Shift-JIS, Big5 and identifier text.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low and returns one result per
// byte: an input register, then range decode and string state update in a
// single pass that carries the one-bit pending-lead state from byte to byte,
// then a result register. Sustained rate is one item per clock unless stalled.
// A stalled result holds while the input register still takes one more item.
// The encoding register may only be written while no item is in flight.
// ----------------------------------------------------------------------------
module multibyte_charset_validator_top #(
	parameter int MAX_STRING_BYTES = mcv_pkg::MAX_STRING_BYTES,
	parameter int OFFSET_W         = $clog2(MAX_STRING_BYTES),
	parameter int COUNT_W          = $clog2(MAX_STRING_BYTES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mcv_pkg::MODE_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [mcv_pkg::KIND_W-1:0] byte_kind,
	output logic [COUNT_W-1:0]         char_number,
	output logic                       error_seen,
	output logic [OFFSET_W-1:0]        error_offset,
	output logic                       string_done
);

	logic [mcv_pkg::MODE_W-1:0] mode_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	logic                       valid_s2;
	logic [mcv_pkg::KIND_W-1:0] kind_s2;
	logic [COUNT_W-1:0]         count_s2;
	logic                       err_s2;
	logic [OFFSET_W-1:0]        err_offset_s2;
	logic                       done_s2;

	logic                       accept;
	logic                       adv;
	mcv_pkg::byte_class_t       cls;
	logic [mcv_pkg::KIND_W-1:0] kind;
	logic [COUNT_W-1:0]         count;
	logic                       err;
	logic [OFFSET_W-1:0]        err_offset;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign accept    = in_valid && !in_stall;

	mcv_classify u_classify (
		.mode      (mode_q),
		.data_byte (data_s1),
		.cls       (cls)
	);

	mcv_track #(
		.MAX_STRING_BYTES (MAX_STRING_BYTES),
		.OFFSET_W         (OFFSET_W),
		.COUNT_W          (COUNT_W)
	) u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cls        (cls),
		.last       (last_s1),
		.kind       (kind),
		.count      (count),
		.err        (err),
		.err_offset (err_offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mcv_pkg::MODE_SJIS;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
			last_s1 <= last;
		end
		if (adv) begin
			kind_s2       <= kind;
			count_s2      <= count;
			err_s2        <= err;
			err_offset_s2 <= err_offset;
			done_s2       <= last_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign byte_kind    = kind_s2;
	assign char_number  = count_s2;
	assign error_seen   = err_s2;
	assign error_offset = err_offset_s2;
	assign string_done  = done_s2;

endmodule
